[design/rpwa_pkg.sv]
// rpwa_pkg: shared widths, codes and constants for the rotated pixel write address block
// no dependencies; used by the channel interfaces and the top level

package rpwa_pkg;

   localparam int POS_W       = 16;
   localparam int COLOR_W     = 4;
   localparam int ADDR_W      = 21;
   localparam int BYTE_W      = 8;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_DATA_W-1:0] PANEL_WIDTH_RESET  = 12'd1024;
   localparam logic [CSR_DATA_W-1:0] PANEL_HEIGHT_RESET = 12'd768;

   localparam logic [BYTE_W-1:0] NIB_LO_MASK = 8'h0F;
   localparam logic [BYTE_W-1:0] NIB_HI_MASK = 8'hF0;
   localparam int GRAY_COLOR_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PANEL_WIDTH  = 3'd0,
      CSR_PANEL_HEIGHT = 3'd1,
      CSR_ROTATION     = 3'd2,
      CSR_GRAY_MODE    = 3'd3,
      CSR_MIRROR_X     = 3'd4,
      CSR_NIBBLE_SWAP  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ROT_0   = 2'd0,
      ROT_90  = 2'd1,
      ROT_180 = 2'd2,
      ROT_270 = 2'd3
   } rot_type;

endpackage

[design/rpwa_if.sv]
// rpwa_req_if / rpwa_rsp_if: valid/ready channels for pixel words and write words
// depends on rpwa_pkg for field widths

interface rpwa_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [rpwa_pkg::POS_W-1:0]    pos_x;
   logic signed [rpwa_pkg::POS_W-1:0]    pos_y;
   logic        [rpwa_pkg::COLOR_W-1:0]  pixel_color;

   modport source (output valid, output pos_x, output pos_y, output pixel_color, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pixel_color, output ready);
endinterface

interface rpwa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                write_enable;
   logic [rpwa_pkg::ADDR_W-1:0]         byte_address;
   logic [rpwa_pkg::BYTE_W-1:0]         write_mask;
   logic [rpwa_pkg::BYTE_W-1:0]         write_data;

   modport source (output valid, output write_enable, output byte_address,
                   output write_mask, output write_data, input ready);
   modport sink   (input valid, input write_enable, input byte_address,
                   input write_mask, input write_data, output ready);
endinterface

[design/rotated_pixel_write_address.sv]
// rotated_pixel_write_address: clips a logical pixel, rotates/mirrors it onto the panel
// and produces a masked framebuffer byte write; depends on rpwa_pkg and rpwa_if
// words are registered in the clip/remap stage, then in the address stage that drives rsp
// one word per cycle unless stalled; the address stage holds the single row-stride multiplier
// both stages keep accepting while downstream is stalled until each holds a word
// reset (synchronous, active high) empties both stages and loads the register reset values

module rotated_pixel_write_address #(
   parameter int MAX_DIM = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [rpwa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rpwa_pkg::CSR_DATA_W-1:0]    csr_write_data,
   rpwa_req_if.sink                           req,
   rpwa_rsp_if.source                         rsp
);
   import rpwa_pkg::*;

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int CRD_W  = $clog2(MAX_DIM);
   localparam int EXT_W  = CSR_DATA_W + 1;
   localparam int PROD_W = CRD_W + DIM_W + 1;

   // configuration registers
   logic [CSR_DATA_W-1:0] panel_width_ff, panel_height_ff;
   rot_type               rotation_ff;
   logic                  gray_mode_ff, mirror_x_ff, nibble_swap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_width_ff  <= PANEL_WIDTH_RESET;
         panel_height_ff <= PANEL_HEIGHT_RESET;
         rotation_ff     <= ROT_0;
         gray_mode_ff    <= 1'b0;
         mirror_x_ff     <= 1'b0;
         nibble_swap_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PANEL_WIDTH:  panel_width_ff  <= csr_write_data;
            CSR_PANEL_HEIGHT: panel_height_ff <= csr_write_data;
            CSR_ROTATION:     rotation_ff     <= rot_type'(csr_write_data[1:0]);
            CSR_GRAY_MODE:    gray_mode_ff    <= csr_write_data[0];
            CSR_MIRROR_X:     mirror_x_ff     <= csr_write_data[0];
            CSR_NIBBLE_SWAP:  nibble_swap_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // effective dimensions, saturated at MAX_DIM
   logic [EXT_W-1:0] w_ext, h_ext;
   logic [DIM_W-1:0] eff_w, eff_h, log_w, log_h, w_m1, h_m1;

   always_comb begin
      w_ext = {1'b0, panel_width_ff};
      h_ext = {1'b0, panel_height_ff};
      eff_w = (w_ext > EXT_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(w_ext);
      eff_h = (h_ext > EXT_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(h_ext);
      log_w = rotation_ff[0] ? eff_h : eff_w;
      log_h = rotation_ff[0] ? eff_w : eff_h;
      w_m1  = eff_w - DIM_W'(1);
      h_m1  = eff_h - DIM_W'(1);
   end

   // handshake: each stage takes a word when empty or when it drains this cycle
   logic a_valid_ff, b_valid_ff;
   logic a_ready, b_ready;

   assign b_ready   = !b_valid_ff || rsp.ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req.ready = a_ready;

   // stage a: clip and remap to physical coordinates
   logic [POS_W-1:0]   x_bits, y_bits;
   logic [CRD_W-1:0]   ux, uy, rot_px, px_in, py_in;
   logic               keep_in;
   logic [CRD_W-1:0]   a_px_ff, a_py_ff;
   logic               a_keep_ff;
   logic [COLOR_W-1:0] a_color_ff;

   always_comb begin
      x_bits  = req.pos_x;
      y_bits  = req.pos_y;
      keep_in = !x_bits[POS_W-1] && !y_bits[POS_W-1]
                && (x_bits < POS_W'(log_w)) && (y_bits < POS_W'(log_h));
      ux = x_bits[CRD_W-1:0];
      uy = y_bits[CRD_W-1:0];
      case (rotation_ff)
         ROT_0: begin
            rot_px = ux;
            py_in  = uy;
         end
         ROT_90: begin
            rot_px = uy;
            py_in  = CRD_W'(h_m1 - DIM_W'(ux));
         end
         ROT_180: begin
            rot_px = CRD_W'(w_m1 - DIM_W'(ux));
            py_in  = CRD_W'(h_m1 - DIM_W'(uy));
         end
         ROT_270: begin
            rot_px = CRD_W'(w_m1 - DIM_W'(uy));
            py_in  = ux;
         end
         default: begin
            rot_px = ux;
            py_in  = uy;
         end
      endcase
      px_in = mirror_x_ff ? CRD_W'(w_m1 - DIM_W'(rot_px)) : rot_px;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && a_ready) begin
         a_keep_ff  <= keep_in;
         a_px_ff    <= px_in;
         a_py_ff    <= py_in;
         a_color_ff <= req.pixel_color;
      end
   end

   // stage b: linear address, mask and data
   logic [DIM_W-1:0]        stride;
   logic [CRD_W-1:0]        offs;
   logic [CRD_W+DIM_W-1:0]  row_base;
   logic [PROD_W-1:0]       linear;
   logic                    slot;
   logic [ADDR_W-1:0]       addr_in;
   logic [BYTE_W-1:0]       mask_in, data_in;
   logic                    b_we_ff;
   logic [ADDR_W-1:0]       b_addr_ff;
   logic [BYTE_W-1:0]       b_mask_ff, b_data_ff;

   always_comb begin
      stride   = gray_mode_ff ? (eff_w >> 1) : eff_w;
      offs     = gray_mode_ff ? (a_px_ff >> 1) : a_px_ff;
      row_base = a_py_ff * stride;
      linear   = PROD_W'(row_base) + PROD_W'(offs);
      slot     = a_px_ff[0] ^ nibble_swap_ff;
      if (gray_mode_ff) begin
         addr_in = ADDR_W'(linear);
         mask_in = slot ? NIB_HI_MASK : NIB_LO_MASK;
         data_in = slot ? {1'b0, a_color_ff[GRAY_COLOR_W-1:0], 4'b0000}
                        : {5'b00000, a_color_ff[GRAY_COLOR_W-1:0]};
      end else begin
         addr_in = ADDR_W'(linear >> 3);
         mask_in = BYTE_W'(1) << a_px_ff[2:0];
         data_in = (a_color_ff != '0) ? mask_in : '0;
      end
      // clipped pixels give an all-zero write
      if (!a_keep_ff) begin
         addr_in = '0;
         mask_in = '0;
         data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && b_ready) begin
         b_we_ff   <= a_keep_ff;
         b_addr_ff <= addr_in;
         b_mask_ff <= mask_in;
         b_data_ff <= data_in;
      end
   end

   assign rsp.valid        = b_valid_ff;
   assign rsp.write_enable = b_we_ff;
   assign rsp.byte_address = b_addr_ff;
   assign rsp.write_mask   = b_mask_ff;
   assign rsp.write_data   = b_data_ff;

   // checks
   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.write_enable |->
         rsp.byte_address == '0 && rsp.write_mask == '0 && rsp.write_data == '0)
      else $error("clipped word carries a nonzero write");

   a_data_in_mask: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.write_data & ~rsp.write_mask) == '0)
      else $error("write data outside write mask");

   a_mono_mask: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.write_enable && !gray_mode_ff |-> $onehot(rsp.write_mask))
      else $error("one-bit mode mask not a single bit");

   a_gray_mask: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.write_enable && gray_mode_ff |->
         rsp.write_mask == NIB_HI_MASK || rsp.write_mask == NIB_LO_MASK)
      else $error("four-bit mode mask not a nibble");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && b_valid_ff && !rsp.ready |-> !req.ready)
      else $error("input taken while both stages are full and stalled");

endmodule

[bench/tb_rotated_pixel_write_address.sv]
// tb_rotated_pixel_write_address: checks clipping, rotation, mirroring and the masked byte
// write of rotated_pixel_write_address against a predictor kept inside this bench
// depends on rpwa_pkg, rpwa_req_if / rpwa_rsp_if and the rotated_pixel_write_address top

module tb_rotated_pixel_write_address;
   import rpwa_pkg::*;

   localparam int PANEL_MAX      = 2048;
   localparam int NUM_DIRECTED   = 25;
   localparam int NUM_PHASES     = 12;
   localparam int PHASE_PIXELS   = 160;
   localparam int HOLD_CYCLES    = 200;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int NO_IDLE_PHASE  = 4;
   localparam int HOLD_PHASE     = 6;
   localparam int DRAIN_PHASE    = 8;

   // indexes with no register behind them
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] width;
      logic [CSR_DATA_W-1:0] height;
      rot_type               rotation;
      logic                  gray;
      logic                  mirror;
      logic                  nswap;
   } panel_setup_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [COLOR_W-1:0]      pixel_color;
   } pixel_type;

   typedef struct packed {
      logic              write_enable;
      logic [ADDR_W-1:0] byte_address;
      logic [BYTE_W-1:0] write_mask;
      logic [BYTE_W-1:0] write_data;
   } pixel_write_type;

   typedef struct packed {
      panel_setup_type setup;
      pixel_type       pixel;
      logic            known;
      pixel_write_type want;
   } directed_row_type;

   localparam panel_setup_type RESET_SETUP = '{PANEL_WIDTH_RESET, PANEL_HEIGHT_RESET, ROT_0,
                                               1'b0, 1'b0, 1'b0};
   localparam panel_setup_type ROT90_SETUP  = '{12'd1024, 12'd768, ROT_90, 1'b0, 1'b0, 1'b0};
   localparam panel_setup_type ROT180_SETUP = '{12'd1024, 12'd768, ROT_180, 1'b0, 1'b0, 1'b0};
   localparam panel_setup_type ROT270_SETUP = '{12'd1024, 12'd768, ROT_270, 1'b0, 1'b0, 1'b0};
   localparam panel_setup_type MIRROR_SETUP = '{12'd1024, 12'd768, ROT_0, 1'b0, 1'b1, 1'b0};
   localparam panel_setup_type GRAY_SETUP   = '{12'd1024, 12'd768, ROT_0, 1'b1, 1'b0, 1'b0};
   localparam panel_setup_type SWAP_SETUP   = '{12'd1024, 12'd768, ROT_0, 1'b1, 1'b0, 1'b1};
   localparam panel_setup_type ODD_SETUP    = '{12'd5, 12'd3, ROT_0, 1'b1, 1'b0, 1'b0};
   localparam panel_setup_type NARROW_SETUP = '{12'd10, 12'd4, ROT_0, 1'b0, 1'b0, 1'b0};
   localparam panel_setup_type ZERO_W_SETUP = '{12'd0, 12'd768, ROT_0, 1'b0, 1'b0, 1'b0};
   localparam panel_setup_type ZERO_H_SETUP = '{12'd1024, 12'd0, ROT_0, 1'b0, 1'b0, 1'b0};
   localparam panel_setup_type HUGE_SETUP   = '{12'd4095, 12'd4095, ROT_0, 1'b0, 1'b0, 1'b0};
   localparam panel_setup_type TINY_SETUP   = '{12'd1, 12'd1, ROT_90, 1'b1, 1'b1, 1'b1};
   localparam panel_setup_type HUGE_ALL     = '{12'd4095, 12'd4095, ROT_270, 1'b1, 1'b1, 1'b1};

   localparam pixel_write_type CLIPPED = '0;

   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{RESET_SETUP,  '{16'sd0, 16'sd0, 4'd1},         1'b1, '{1'b1, 21'd0, 8'h01, 8'h01}},
      '{RESET_SETUP,  '{16'sd1023, 16'sd767, 4'd15},   1'b1, '{1'b1, 21'd98303, 8'h80, 8'h80}},
      '{RESET_SETUP,  '{16'sd1024, 16'sd0, 4'd1},      1'b1, CLIPPED},
      '{RESET_SETUP,  '{16'sd0, 16'sd768, 4'd1},       1'b1, CLIPPED},
      '{RESET_SETUP,  '{-16'sd1, 16'sd5, 4'd3},        1'b1, CLIPPED},
      '{RESET_SETUP,  '{16'sh8000, 16'sh7FFF, 4'd0},   1'b1, CLIPPED},
      '{RESET_SETUP,  '{16'sh7FFF, 16'sh8000, 4'd15},  1'b1, CLIPPED},
      '{RESET_SETUP,  '{16'sd5, 16'sd0, 4'd0},         1'b1, '{1'b1, 21'd0, 8'h20, 8'h00}},
      '{ROT90_SETUP,  '{16'sd767, 16'sd1023, 4'd9},    1'b0, CLIPPED},
      '{ROT90_SETUP,  '{16'sd0, 16'sd0, 4'd2},         1'b0, CLIPPED},
      '{ROT180_SETUP, '{16'sd0, 16'sd0, 4'd5},         1'b0, CLIPPED},
      '{ROT270_SETUP, '{16'sd10, 16'sd20, 4'd7},       1'b0, CLIPPED},
      '{ROT270_SETUP, '{16'sd768, 16'sd0, 4'd1},       1'b1, CLIPPED},
      '{MIRROR_SETUP, '{16'sd3, 16'sd4, 4'd1},         1'b0, CLIPPED},
      '{GRAY_SETUP,   '{16'sd0, 16'sd0, 4'd15},        1'b1, '{1'b1, 21'd0, 8'h0F, 8'h07}},
      '{GRAY_SETUP,   '{16'sd1, 16'sd0, 4'd15},        1'b1, '{1'b1, 21'd0, 8'hF0, 8'h70}},
      '{SWAP_SETUP,   '{16'sd0, 16'sd0, 4'd15},        1'b1, '{1'b1, 21'd0, 8'hF0, 8'h70}},
      '{ODD_SETUP,    '{16'sd4, 16'sd0, 4'd6},         1'b0, CLIPPED},
      '{ODD_SETUP,    '{16'sd0, 16'sd1, 4'd6},         1'b0, CLIPPED},
      '{NARROW_SETUP, '{16'sd9, 16'sd1, 4'd1},         1'b0, CLIPPED},
      '{ZERO_W_SETUP, '{16'sd0, 16'sd0, 4'd1},         1'b1, CLIPPED},
      '{ZERO_H_SETUP, '{16'sd0, 16'sd0, 4'd1},         1'b1, CLIPPED},
      '{HUGE_SETUP,   '{16'sd2047, 16'sd2047, 4'd1},   1'b0, CLIPPED},
      '{HUGE_SETUP,   '{16'sd2048, 16'sd0, 4'd1},      1'b1, CLIPPED},
      '{TINY_SETUP,   '{16'sd0, 16'sd0, 4'd8},         1'b0, CLIPPED}
   };

   logic clock;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   rpwa_req_if req_ch ();
   rpwa_rsp_if rsp_ch ();

   rotated_pixel_write_address #(.MAX_DIM(PANEL_MAX)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch)
   );

   panel_setup_type  panel_regs;
   pixel_write_type  pending_writes [$];
   bit               idle_on;
   int               holds_asked;
   int               holds_taken;
   int               hold_left;
   int               error_count;
   int               writes_checked;
   int               cycle_count;
   int               random_sent;
   int               setups_used;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int clamp_dim(logic [CSR_DATA_W-1:0] d);
      return (d > PANEL_MAX) ? PANEL_MAX : int'(d);
   endfunction

   // expected byte write for one pixel under one register setting
   function automatic pixel_write_type compute_write(panel_setup_type c, pixel_type p);
      int w, h, lw, lh, sx, sy, px, py, lin;
      logic slot;
      pixel_write_type r;
      r = '0;
      w = clamp_dim(c.width);
      h = clamp_dim(c.height);
      lw = (c.rotation == ROT_90 || c.rotation == ROT_270) ? h : w;
      lh = (c.rotation == ROT_90 || c.rotation == ROT_270) ? w : h;
      sx = int'(p.pos_x);
      sy = int'(p.pos_y);
      if (sx < 0 || sy < 0 || sx >= lw || sy >= lh) return r;
      case (c.rotation)
         ROT_0: begin
            px = sx;
            py = sy;
         end
         ROT_90: begin
            px = sy;
            py = h - 1 - sx;
         end
         ROT_180: begin
            px = w - 1 - sx;
            py = h - 1 - sy;
         end
         default: begin
            px = w - 1 - sy;
            py = sx;
         end
      endcase
      if (c.mirror) px = w - 1 - px;
      r.write_enable = 1'b1;
      if (!c.gray) begin
         lin = (py * w + px) / 8;
         r.write_mask = BYTE_W'(1 << (px % 8));
         r.write_data = (p.pixel_color != 0) ? r.write_mask : '0;
      end else begin
         // odd widths leave the last pixel of a row sharing a byte with the next row
         slot = px[0] ^ c.nswap;
         lin = py * (w / 2) + px / 2;
         r.write_mask = slot ? NIB_HI_MASK : NIB_LO_MASK;
         r.write_data = slot ? {1'b0, p.pixel_color[GRAY_COLOR_W-1:0], 4'h0}
                             : {5'h0, p.pixel_color[GRAY_COLOR_W-1:0]};
      end
      r.byte_address = ADDR_W'(lin);
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_dim();
      case ($urandom_range(9))
         0: return CSR_DATA_W'($urandom);
         1: begin
            case ($urandom_range(3))
               0: return '0;
               1: return 12'd1;
               2: return CSR_DATA_W'(PANEL_MAX);
               default: return '1;
            endcase
         end
         2, 3, 4: return CSR_DATA_W'($urandom_range(16, 1));
         default: return CSR_DATA_W'($urandom_range(PANEL_MAX, 17));
      endcase
   endfunction

   function automatic panel_setup_type pick_setup();
      panel_setup_type c;
      c.width = pick_dim();
      c.height = pick_dim();
      c.rotation = rot_type'($urandom_range(3));
      c.gray = 1'($urandom_range(1));
      c.mirror = 1'($urandom_range(1));
      c.nswap = 1'($urandom_range(1));
      return c;
   endfunction

   // mostly in-bounds pixels, some on the clip edges, some anywhere in the 16-bit range
   function automatic pixel_type pick_pixel(panel_setup_type c);
      int lw, lh;
      pixel_type p;
      lw = (c.rotation == ROT_90 || c.rotation == ROT_270) ? clamp_dim(c.height)
                                                         : clamp_dim(c.width);
      lh = (c.rotation == ROT_90 || c.rotation == ROT_270) ? clamp_dim(c.width)
                                                         : clamp_dim(c.height);
      p.pos_x = POS_W'($urandom);
      p.pos_y = POS_W'($urandom);
      p.pixel_color = COLOR_W'($urandom);
      case ($urandom_range(9))
         0, 1: ;
         2: begin
            case ($urandom_range(3))
               0: p.pos_x = POS_W'(-1);
               1: p.pos_x = '0;
               2: p.pos_x = POS_W'(lw - 1);
               default: p.pos_x = POS_W'(lw);
            endcase
            case ($urandom_range(3))
               0: p.pos_y = POS_W'(-1);
               1: p.pos_y = '0;
               2: p.pos_y = POS_W'(lh - 1);
               default: p.pos_y = POS_W'(lh);
            endcase
         end
         default: begin
            if (lw > 0 && lh > 0) begin
               p.pos_x = POS_W'($urandom_range(lw - 1));
               p.pos_y = POS_W'($urandom_range(lh - 1));
            end
         end
      endcase
      return p;
   endfunction

   // one register write; the local copy follows the same index decode and masking
   task automatic csr_poke(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = d;
      case (idx)
         CSR_PANEL_WIDTH:  panel_regs.width = d;
         CSR_PANEL_HEIGHT: panel_regs.height = d;
         CSR_ROTATION:     panel_regs.rotation = rot_type'(d[1:0]);
         CSR_GRAY_MODE:    panel_regs.gray = d[0];
         CSR_MIRROR_X:     panel_regs.mirror = d[0];
         CSR_NIBBLE_SWAP:  panel_regs.nswap = d[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // waits for the block to go idle, then writes all six registers
   task automatic load_panel_setup(input panel_setup_type c);
      req_ch.valid = 1'b0;
      while (pending_writes.size() != 0) @(negedge clock);
      csr_poke(CSR_PANEL_WIDTH, c.width);
      csr_poke(CSR_PANEL_HEIGHT, c.height);
      csr_poke(CSR_ROTATION, {10'($urandom), 2'(c.rotation)});
      csr_poke(CSR_GRAY_MODE, {11'($urandom), c.gray});
      csr_poke(CSR_MIRROR_X, {11'($urandom), c.mirror});
      csr_poke(CSR_NIBBLE_SWAP, {11'($urandom), c.nswap});
      csr_write_enable = 1'b0;
      setups_used++;
   endtask

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_pixel(input pixel_type p, input pixel_write_type want);
      while (idle_on && $urandom_range(99) < 26) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.pos_x = p.pos_x;
      req_ch.pos_y = p.pos_y;
      req_ch.pixel_color = p.pixel_color;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_writes.push_back(want);
      @(negedge clock);
   endtask

   // result side ready, with long hold-offs asked for by the stimulus
   always @(negedge clock) begin
      if (hold_left == 0 && holds_taken != holds_asked) begin
         hold_left = HOLD_CYCLES;
         holds_taken++;
      end
      if (hold_left != 0) begin
         rsp_ch.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready = !(idle_on && $urandom_range(99) < 26);
      end
   end

   always @(posedge clock) begin
      pixel_write_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_writes.size() == 0) begin
            $error("unexpected write word: addr %0h mask %0h data %0h",
                   rsp_ch.byte_address, rsp_ch.write_mask, rsp_ch.write_data);
            error_count++;
         end else begin
            want = pending_writes.pop_front();
            writes_checked++;
            if (rsp_ch.write_enable !== want.write_enable) begin
               $error("write_enable: expected %0d, got %0d",
                      want.write_enable, rsp_ch.write_enable);
               error_count++;
            end
            if (rsp_ch.byte_address !== want.byte_address) begin
               $error("byte_address: expected %0h, got %0h",
                      want.byte_address, rsp_ch.byte_address);
               error_count++;
            end
            if (rsp_ch.write_mask !== want.write_mask) begin
               $error("write_mask: expected %0h, got %0h", want.write_mask, rsp_ch.write_mask);
               error_count++;
            end
            if (rsp_ch.write_data !== want.write_data) begin
               $error("write_data: expected %0h, got %0h", want.write_data, rsp_ch.write_data);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rotated_pixel_write_address verification failed");
         $finish;
      end
   end

   initial begin
      panel_setup_type setup;
      pixel_type pix;
      directed_row_type row;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.pixel_color = '0;
      panel_regs = RESET_SETUP;
      idle_on = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // writes to unused indexes must leave the reset values alone
      csr_poke(CSR_SPARE_A, CSR_DATA_W'($urandom));
      csr_poke(CSR_SPARE_B, CSR_DATA_W'($urandom));
      csr_write_enable = 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.setup != panel_regs) load_panel_setup(row.setup);
         send_pixel(row.pixel, row.known ? row.want : compute_write(panel_regs, row.pixel));
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase == 0) setup = HUGE_ALL;
         else if (phase == 1) setup = TINY_SETUP;
         else setup = pick_setup();
         load_panel_setup(setup);
         idle_on = (phase != NO_IDLE_PHASE);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            if (phase == HOLD_PHASE && n == 20) holds_asked++;
            if (phase == DRAIN_PHASE && n == 80) begin
               req_ch.valid = 1'b0;
               while (pending_writes.size() != 0) @(negedge clock);
            end
            pix = pick_pixel(panel_regs);
            send_pixel(pix, compute_write(panel_regs, pix));
            random_sent++;
         end
      end

      req_ch.valid = 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d directed and %0d random pixel words over %0d register settings",
               NUM_DIRECTED, random_sent, setups_used);
      $display("%0d write words checked, %0d mismatches", writes_checked, error_count);
      if (error_count == 0) begin
         $display("rotated_pixel_write_address verification clean");
      end else begin
         $display("rotated_pixel_write_address verification failed");
      end
      $finish;
   end

endmodule
